// ===== hdl/scan_line_pixel_timer_macros.svh =====
// assertion shorthands for the scan line timer checks
`ifndef SCAN_LINE_PIXEL_TIMER_MACROS_SVH
`define SCAN_LINE_PIXEL_TIMER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SLPT_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan line timer check failed");

// property that must hold in the cycle after its trigger
`define SLPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan line timer check failed");

`endif

// ===== hdl/slpt_pkg.sv =====
package slpt_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int WIDE_W   = 40;
    localparam int PIX_W    = 12;
    localparam int ADDR_F_W = 5;
    localparam int LROW_W   = 5;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // n / 100 == (n * UNIT_MAGIC) >> UNIT_SHIFT for every 32-bit n
    localparam logic [TIME_W-1:0] UNIT_MAGIC = 32'd1374389535;
    localparam int UNIT_SHIFT = 37;
    // a 32-bit span over 100 stays below 2^26
    localparam int UNIT_W = 26;
    // units times an 8-bit register count
    localparam int PROD_W = UNIT_W + CFG_W;

    localparam logic [PIX_W-1:0]  ALL_ON           = 12'hFFF;
    localparam logic [TIME_W-1:0] FRAME_PERIOD_RST = 32'd1000;
    localparam logic [CFG_W-1:0]  LEAD_RST         = 8'd15;
    localparam logic [CFG_W-1:0]  DRAW_RST         = 8'd70;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_FRAME = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAD = 1'b0,
        REG_DRAW = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [TIME_W-1:0]   time_us;
        logic [ADDR_F_W-1:0] write_row;
        logic [ADDR_F_W-1:0] write_col;
        logic [PIX_W-1:0]    write_pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [LROW_W-1:0] line_row;
        logic [WIDE_W-1:0] lead_wait_us;
        logic [WIDE_W-1:0] hold_us;
        logic              last;
    } out_item_t;

    // timing snapshot handed to the line calculator
    typedef struct packed {
        logic [TIME_W-1:0] dline_us;
        logic [TIME_W-1:0] elapsed_us;
        logic [TIME_W-1:0] period_us;
        logic [CFG_W-1:0]  lead_units;
        logic [CFG_W-1:0]  draw_units;
    } snap_t;

    // per-line timing result
    typedef struct packed {
        logic [WIDE_W-1:0] lead_wait_us;
        logic [WIDE_W-1:0] hold_us;
    } line_t;

endpackage

// ===== hdl/slpt_store.sv =====
module slpt_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [slpt_pkg::PIX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [slpt_pkg::PIX_W-1:0] rd_data
);
    import slpt_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/slpt_calc.sv =====
module slpt_calc #(
    parameter int ROWS = 32,
    parameter int COLS = 32,
    parameter int RW   = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  slpt_pkg::snap_t snap,
    output logic            done,
    output slpt_pkg::line_t res,
    output logic [RW-1:0]   row
);
    import slpt_pkg::*;

    // row quotient is below ROWS once the frame has not overrun
    localparam int QW     = RW;
    localparam int NUM_W  = TIME_W + QW;
    localparam int CW     = $clog2(COLS + 1);
    // hold over COLS by reciprocal multiplication, exact over the operand ranges
    localparam int CL     = $clog2(COLS);
    localparam int US     = UNIT_W + CL;
    localparam int UM_W   = UNIT_W + 1;
    localparam int UP_W   = UNIT_W + UM_W;
    localparam longint UM = ((longint'(1) << US) + COLS - 1) / COLS;
    localparam int TW     = CFG_W + CW;
    localparam int TS     = TW + CL;
    localparam int TP_W   = 2 * TW + 1;
    localparam longint TM = ((longint'(1) << TS) + COLS - 1) / COLS;
    // hold pipeline steps
    localparam int H_MUL   = 0;
    localparam int H_SPLIT = 1;
    localparam int H_PART  = 2;
    localparam int H_FRAC  = 3;
    localparam int H_SUM   = 4;
    localparam int HITER   = 5;
    localparam int MAXIT  = (HITER > QW) ? HITER : QW;
    localparam int IT_W   = $clog2(MAXIT + 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_PROD,
        C_DIV
    } cstate_t;

    cstate_t state_reg;

    logic [TIME_W-1:0] dline_reg;
    logic [TIME_W-1:0] elap_reg;
    logic [TIME_W-1:0] per_reg;
    logic [CFG_W-1:0]  lead_u_reg;
    logic [CFG_W-1:0]  draw_u_reg;
    logic [63:0]       mprod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              sat_reg;
    logic [PROD_W-1:0] lead_reg;
    logic [UP_W-1:0]   uprod_reg;
    logic [UNIT_W-1:0] uq_reg;
    logic [CW-1:0]     ur_reg;
    logic [PROD_W-1:0] hq_reg;
    logic [TW-1:0]     t_reg;
    logic [TP_W-1:0]   tprod_reg;
    logic [PROD_W-1:0] hd_reg;
    logic [TIME_W-1:0] rrem_reg;
    logic [QW-1:0]     rsh_reg;
    logic [QW-1:0]     q_reg;
    logic [IT_W-1:0]   cnt_reg;
    logic              done_reg;

    logic [UNIT_W-1:0] unit;
    logic [UNIT_W-1:0] uq;
    logic [CW-1:0]     ur;
    logic [TIME_W:0]   rtrial;
    logic [TIME_W-1:0] rrem_next;
    logic [QW-1:0]     q_next;
    logic              rbit;

    // line period over 100
    assign unit = mprod_reg[UNIT_SHIFT+UNIT_W-1:UNIT_SHIFT];

    // unit split into quotient and remainder by COLS
    assign uq = UNIT_W'(uprod_reg >> US);
    assign ur = CW'(unit - UNIT_W'(uq * UNIT_W'(COLS)));

    // row divider: one restoring step per cycle by the frame period
    always_comb
    begin
        rtrial = {rrem_reg, rsh_reg[QW-1]};
        rbit   = (rtrial >= {1'b0, per_reg});
        if (rbit)
        begin
            rrem_next = rtrial[TIME_W-1:0] - per_reg;
        end
        else
        begin
            rrem_next = rtrial[TIME_W-1:0];
        end
        q_next = (q_reg << 1) | QW'(rbit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    state_reg <= C_PROD;
                end
                C_PROD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IT_W'(MAXIT - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            dline_reg  <= snap.dline_us;
            elap_reg   <= snap.elapsed_us;
            per_reg    <= snap.period_us;
            lead_u_reg <= snap.lead_units;
            draw_u_reg <= snap.draw_units;
        end
        if (state_reg == C_MUL)
        begin
            mprod_reg <= 64'(dline_reg) * 64'(UNIT_MAGIC);
            num_reg   <= NUM_W'(elap_reg) * NUM_W'(ROWS);
            // also covers a zero frame period
            sat_reg   <= (elap_reg >= per_reg);
        end
        if (state_reg == C_PROD)
        begin
            lead_reg <= PROD_W'(lead_u_reg) * PROD_W'(unit);
            // upper dividend bits are below the period, so start there
            rrem_reg <= num_reg[NUM_W-1:QW];
            rsh_reg  <= num_reg[QW-1:0];
            q_reg    <= '0;
        end
        if (state_reg == C_DIV)
        begin
            // hold: draw times unit quotient, plus draw times remainder over COLS
            if (cnt_reg == IT_W'(H_MUL))
            begin
                uprod_reg <= UP_W'(unit) * UP_W'(UM);
            end
            if (cnt_reg == IT_W'(H_SPLIT))
            begin
                uq_reg <= uq;
                ur_reg <= ur;
            end
            if (cnt_reg == IT_W'(H_PART))
            begin
                hq_reg <= PROD_W'(draw_u_reg) * PROD_W'(uq_reg);
                t_reg  <= TW'(draw_u_reg) * TW'(ur_reg);
            end
            if (cnt_reg == IT_W'(H_FRAC))
            begin
                tprod_reg <= TP_W'(t_reg) * TP_W'(TM);
            end
            if (cnt_reg == IT_W'(H_SUM))
            begin
                hd_reg <= hq_reg + PROD_W'(tprod_reg >> TS);
            end
            if (cnt_reg < IT_W'(QW))
            begin
                rrem_reg <= rrem_next;
                rsh_reg  <= rsh_reg << 1;
                q_reg    <= q_next;
            end
        end
    end

    assign done             = done_reg;
    assign res.lead_wait_us = WIDE_W'(lead_reg);
    assign res.hold_us      = WIDE_W'(hd_reg);
    assign row              = sat_reg ? RW'(ROWS - 1) : q_reg;

endmodule

// ===== hdl/scan_line_pixel_timer.sv =====
// line trigger: the calculator runs its multiply and product states, then the bit-per-cycle row divider
// alongside the five-step hold pipeline; the pixels are then read through the registered store port
// and leave as one beat per cycle, while the receiver does not stall, for the COLS pixels and the
// closing all-on word; the input stalls until the closing word is taken
// frame trigger, pixel write and unused op: taken without a stall, no beats
// reset (async, active low): timing state and unit registers to defaults, store undefined
module scan_line_pixel_timer #(
    parameter int ROWS = 32,
    parameter int COLS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  slpt_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output slpt_pkg::out_item_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [slpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slpt_pkg::CFG_W-1:0]     cfg_data
);
    import slpt_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(COLS + 1);
    localparam int RCMP_W = $clog2(ROWS + 1) + 1;
    localparam int CCMP_W = $clog2(COLS + 1) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT,
        S_LAST
    } state_t;

    state_t state_reg;

    logic [TIME_W-1:0] line_start_reg;
    logic [TIME_W-1:0] frame_start_reg;
    logic [TIME_W-1:0] frame_period_reg;
    logic [CFG_W-1:0]  lead_units_reg;
    logic [CFG_W-1:0]  draw_units_reg;

    logic [CNT_W-1:0]  iss_reg;
    logic [CNT_W-1:0]  col_reg;
    logic              pend_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [RW-1:0]     row_reg;
    logic [AW-1:0]     base_reg;
    logic [WIDE_W-1:0] lead_reg;
    logic [WIDE_W-1:0] hold_reg;

    logic              in_acc;
    logic              calc_start;
    snap_t             snap;
    logic              calc_done;
    line_t             calc_res;
    logic [RW-1:0]     calc_row;
    logic              wr_ok;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              slot_free;
    logic              load_pix;
    logic              load_last;
    logic              issue;
    logic [AW-1:0]     rd_addr;
    logic [PIX_W-1:0]  rd_data;

    // input handshake
    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign calc_start = in_acc && (in_data.op == OP_LINE);

    // timing snapshot, spans wrap modulo 2^32
    assign snap.dline_us   = in_data.time_us - line_start_reg;
    assign snap.elapsed_us = in_data.time_us - frame_start_reg;
    assign snap.period_us  = frame_period_reg;
    assign snap.lead_units = lead_units_reg;
    assign snap.draw_units = draw_units_reg;

    // pixel write, out-of-range addresses dropped
    assign wr_ok   = (RCMP_W'(in_data.write_row) < RCMP_W'(ROWS))
                  && (CCMP_W'(in_data.write_col) < CCMP_W'(COLS));
    assign wr_en   = in_acc && (in_data.op == OP_WRITE) && wr_ok;
    assign wr_addr = AW'(AW'(in_data.write_row) * AW'(COLS) + AW'(in_data.write_col));

    // output slot and read issue
    assign slot_free = !out_valid_reg || !out_stall;
    assign load_pix  = (state_reg == S_EMIT) && pend_reg && slot_free;
    assign load_last = (state_reg == S_LAST) && slot_free;
    assign issue     = (state_reg == S_EMIT) && (iss_reg < CNT_W'(COLS))
                    && (!pend_reg || load_pix);
    assign rd_addr   = base_reg + AW'(iss_reg);

    slpt_calc #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW)
    ) u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .snap  (snap),
        .done  (calc_done),
        .res   (calc_res),
        .row   (calc_row)
    );

    slpt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.write_pixel),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state, timing state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            line_start_reg   <= '0;
            frame_start_reg  <= '0;
            frame_period_reg <= FRAME_PERIOD_RST;
            lead_units_reg   <= LEAD_RST;
            draw_units_reg   <= DRAW_RST;
            iss_reg          <= '0;
            col_reg          <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_LEAD: lead_units_reg <= cfg_data;
                    REG_DRAW: draw_units_reg <= cfg_data;
                    default:  ;
                endcase
            end

            if (load_pix || load_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (in_data.op)
                            OP_LINE:
                            begin
                                line_start_reg <= in_data.time_us;
                                state_reg      <= S_CALC;
                            end
                            OP_FRAME:
                            begin
                                frame_period_reg <= in_data.time_us - frame_start_reg;
                                frame_start_reg  <= in_data.time_us;
                            end
                            OP_WRITE: ;
                            OP_NONE:  ;
                            default:  ;
                        endcase
                    end
                end
                S_CALC:
                begin
                    if (calc_done)
                    begin
                        iss_reg   <= '0;
                        col_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (issue)
                    begin
                        iss_reg  <= iss_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else if (load_pix)
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (load_pix)
                    begin
                        col_reg <= col_reg + 1'b1;
                        if (col_reg == CNT_W'(COLS - 1))
                        begin
                            state_reg <= S_LAST;
                        end
                    end
                end
                S_LAST:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // line payload and output beat
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC && calc_done)
        begin
            row_reg  <= calc_row;
            base_reg <= AW'(AW'(calc_row) * AW'(COLS));
            lead_reg <= calc_res.lead_wait_us;
            hold_reg <= calc_res.hold_us;
        end
        if (load_pix)
        begin
            out_reg.pixel        <= rd_data;
            out_reg.line_row     <= LROW_W'(row_reg);
            out_reg.lead_wait_us <= (col_reg == '0) ? lead_reg : '0;
            out_reg.hold_us      <= hold_reg;
            out_reg.last         <= 1'b0;
        end
        else if (load_last)
        begin
            out_reg.pixel        <= ALL_ON;
            out_reg.line_row     <= LROW_W'(row_reg);
            out_reg.lead_wait_us <= '0;
            out_reg.hold_us      <= '0;
            out_reg.last         <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/slpt_chk.sv =====
`include "scan_line_pixel_timer_macros.svh"

module slpt_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input slpt_pkg::in_item_t             in_data,
    input logic                           out_valid,
    input logic                           out_stall,
    input slpt_pkg::out_item_t            out_data
);
    import slpt_pkg::*;

    logic in_acc;
    logic pix_acc;
    logic close_ok;

    // accepted beats and the shape of the closing word
    assign in_acc   = in_valid && !in_stall;
    assign pix_acc  = out_valid && !out_stall && !out_data.last;
    assign close_ok = (out_data.pixel == ALL_ON) && (out_data.hold_us == '0)
                   && (out_data.lead_wait_us == '0);

    // a line trigger holds off the next item while the line is worked
    `SLPT_ASSERT_NEXT(a_line_blocks, in_acc && (in_data.op == OP_LINE), in_stall)

    // closing word is all-on with no wait and no hold
    `SLPT_ASSERT_NOW(a_close_word, out_valid && out_data.last, close_ok)

    // within a line the row does not change
    `SLPT_ASSERT_NEXT(a_row_held, pix_acc, !out_valid || $stable(out_data.line_row))

    // only the first pixel of a line carries a lead wait
    `SLPT_ASSERT_NEXT(a_lead_first, pix_acc, !out_valid || (out_data.lead_wait_us == '0))

    // a stalled beat holds
    `SLPT_ASSERT_NEXT(a_beat_held, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind scan_line_pixel_timer slpt_chk u_slpt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/tb_scan_line_pixel_timer.sv =====
module tb_scan_line_pixel_timer;
    timeunit 1ns;
    timeprecision 1ps;

    import slpt_pkg::*;

    localparam int ROWS        = 32;
    localparam int COLS        = 32;
    localparam int LINE_CYCLES = COLS + 15;
    localparam int SETTLE      = 2 * LINE_CYCLES;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 1000000;
    localparam int MAX_REPORTS = 40;

    // predicts the beats of each line from the raster timing state
    class raster_board;
        logic [CFG_W-1:0]  lead_units;
        logic [CFG_W-1:0]  draw_units;
        logic [TIME_W-1:0] line_start;
        logic [TIME_W-1:0] frame_start;
        logic [TIME_W-1:0] frame_period;
        logic [PIX_W-1:0]  image [ROWS*COLS];
        out_item_t         pending_beats [$];
        int                errors;

        function new();
            lead_units   = LEAD_RST;
            draw_units   = DRAW_RST;
            line_start   = '0;
            frame_start  = '0;
            frame_period = FRAME_PERIOD_RST;
            errors       = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
            if (idx == REG_LEAD)
                lead_units = value;
            else
                draw_units = value;
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        // elapsed part of the frame scaled to rows, clamped to the last row
        function logic [LROW_W-1:0] row_of(logic [TIME_W-1:0] now);
            logic [63:0] scaled;
            if (frame_period == '0)
                return LROW_W'(ROWS - 1);
            scaled = ({32'b0, now - frame_start} * 64'(ROWS)) / {32'b0, frame_period};
            if (scaled >= 64'(ROWS))
                return LROW_W'(ROWS - 1);
            return LROW_W'(scaled);
        endfunction

        function void note_item(in_item_t it);
            logic [TIME_W-1:0] span;
            logic [WIDE_W-1:0] unit;
            logic [WIDE_W-1:0] lead;
            logic [WIDE_W-1:0] hold;
            logic [LROW_W-1:0] row;
            out_item_t         beat;
            case (it.op)
                OP_LINE:
                begin
                    span = it.time_us - line_start;
                    unit = {8'b0, span / 32'd100};
                    lead = {32'b0, lead_units} * unit;
                    hold = ({32'b0, draw_units} * unit) / WIDE_W'(COLS);
                    row  = row_of(it.time_us);
                    for (int c = 0; c < COLS; c++)
                    begin
                        beat.pixel        = image[int'(row) * COLS + c];
                        beat.line_row     = row;
                        beat.lead_wait_us = (c == 0) ? lead : '0;
                        beat.hold_us      = hold;
                        beat.last         = 1'b0;
                        pending_beats.push_back(beat);
                    end
                    beat.pixel        = ALL_ON;
                    beat.line_row     = row;
                    beat.lead_wait_us = '0;
                    beat.hold_us      = '0;
                    beat.last         = 1'b1;
                    pending_beats.push_back(beat);
                    line_start = it.time_us;
                end
                OP_FRAME:
                begin
                    frame_period = it.time_us - frame_start;
                    frame_start  = it.time_us;
                end
                OP_WRITE:
                begin
                    if (int'(it.write_row) < ROWS && int'(it.write_col) < COLS)
                        image[int'(it.write_row) * COLS + int'(it.write_col)] = it.write_pixel;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void check_beat(out_item_t got);
            out_item_t want;
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: beat expected none actual %0h", $time, got);
                return;
            end
            want = pending_beats.pop_front();
            if (got.pixel !== want.pixel)
                flag("pixel", 64'(want.pixel), 64'(got.pixel));
            if (got.line_row !== want.line_row)
                flag("line_row", 64'(want.line_row), 64'(got.line_row));
            if (got.lead_wait_us !== want.lead_wait_us)
                flag("lead_wait_us", 64'(want.lead_wait_us), 64'(got.lead_wait_us));
            if (got.hold_us !== want.hold_us)
                flag("hold_us", 64'(want.hold_us), 64'(got.hold_us));
            if (got.last !== want.last)
                flag("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    raster_board sb = new();

    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    bit          hold_req = 1'b0;
    int          cycles = 0;
    logic [31:0] now_us = '0;
    int          lines_per_frame = 8;

    scan_line_pixel_timer #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("scan_line_pixel_timer: mismatch");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(out_data);
    end

    // receiver stall bursts and the long hold-off
    initial
    begin
        bit v;
        int n;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                v = 1'b1;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (!sink_idle)
            begin
                v = 1'b0;
                n = 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                v = 1'b1;
                n = $urandom_range(1, 13);
            end
            else
            begin
                v = 1'b0;
                n = $urandom_range(1, 24);
            end
            out_stall <= v;
            repeat (n - 1) @(negedge clk);
        end
    end

    function automatic in_item_t make_item(op_t op, logic [31:0] t);
        in_item_t it;
        it.op          = op;
        it.time_us     = t;
        it.write_row   = ADDR_F_W'($urandom_range(0, ROWS - 1));
        it.write_col   = ADDR_F_W'($urandom_range(0, COLS - 1));
        it.write_pixel = PIX_W'($urandom_range(0, 4095));
        return it;
    endfunction

    // one input beat, with an optional sender gap in front of it
    task automatic send_beat(in_item_t it);
        int n;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic send_write(int r, int c, logic [PIX_W-1:0] p);
        in_item_t it;
        it = make_item(OP_WRITE, $urandom());
        it.write_row   = ADDR_F_W'(r);
        it.write_col   = ADDR_F_W'(c);
        it.write_pixel = p;
        send_beat(it);
    endtask

    // let every line drain before touching the registers
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] lead, logic [CFG_W-1:0] draw);
        quiesce();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LEAD;
        cfg_data  <= lead;
        @(posedge clk);
        sb.set_reg(REG_LEAD, lead);
        @(negedge clk);
        cfg_index <= REG_DRAW;
        cfg_data  <= draw;
        @(posedge clk);
        sb.set_reg(REG_DRAW, draw);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly regular frames of lines with writes mixed in, plus some noise
    task automatic run_traffic(int n_items);
        int          cnt;
        int          lp;
        in_item_t    it;
        cnt = 0;
        while (cnt < n_items)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                if ($urandom_range(0, 9) < 3)
                    lines_per_frame = $urandom_range(1, 36);
                if ($urandom_range(0, 15) == 0)
                    now_us = $urandom();
                lp = $urandom_range(100, 30000);
                send_beat(make_item(OP_FRAME, now_us));
                cnt++;
                for (int k = 0; k < lines_per_frame && cnt < n_items + 8; k++)
                begin
                    now_us = now_us + lp + $urandom_range(0, lp / 8);
                    if ($urandom_range(0, 9) < 3)
                    begin
                        send_beat(make_item(OP_WRITE, $urandom()));
                        cnt++;
                    end
                    send_beat(make_item(OP_LINE, now_us));
                    cnt++;
                end
                now_us = now_us + lp;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    it = make_item(op_t'($urandom_range(0, 3)), $urandom());
                    send_beat(it);
                    if (it.op != OP_NONE)
                        cnt++;
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_LEAD;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole image so that no line reads an unwritten word
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                send_write(r, c, PIX_W'($urandom_range(0, 4095)));

        // directed part at reset settings
        send_write(0, 0, 12'h000);
        send_write(ROWS - 1, COLS - 1, 12'hFFF);
        send_beat(make_item(OP_LINE, 32'd0));
        send_beat(make_item(OP_LINE, 32'd500));
        // elapsed reaches a full frame: row clamps to the last
        send_beat(make_item(OP_LINE, 32'd1000));
        send_beat(make_item(OP_NONE, $urandom()));
        send_beat(make_item(OP_FRAME, 32'd1000));
        // zero frame period: last row
        send_beat(make_item(OP_FRAME, 32'd1000));
        send_beat(make_item(OP_LINE, 32'd1300));

        // directed part at the top register values, timestamps wrapping
        program_regs(8'd255, 8'd255);
        send_beat(make_item(OP_FRAME, 32'hFFFF_FFF0));
        send_beat(make_item(OP_FRAME, 32'h0000_0010));
        send_beat(make_item(OP_LINE, 32'h0000_0018));
        send_beat(make_item(OP_LINE, 32'h0000_0017));
        send_beat(make_item(OP_LINE, 32'h0000_0017));
        send_beat(make_item(OP_LINE, 32'h0000_0017 + 32'd99));
        send_beat(make_item(OP_LINE, 32'h0000_0017 + 32'd199));

        // random part over several register settings
        program_regs(8'd0, 8'd0);
        run_traffic(60);

        // long receiver hold-off while lines keep coming
        program_regs(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
        src_idle = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
        begin
            now_us = now_us + $urandom_range(100, 5000);
            send_beat(make_item(OP_LINE, now_us));
        end
        src_idle = 1'b1;

        program_regs(8'd1, 8'd254);
        run_traffic(50);
        program_regs(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
        run_traffic(50);

        // closing part without idling
        program_regs(LEAD_RST, DRAW_RST);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        run_traffic(40);

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("scan_line_pixel_timer: match");
        else
            $display("scan_line_pixel_timer: mismatch");
        $finish;
    end

endmodule
